// ----- rtl/gqg_pkg.sv -----
// Shared types, constants and helpers of the glyph quad generator.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package gqg_pkg;

   localparam int GLYPHS_DEFAULT = 256;

   localparam int POS_W   = 21;
   localparam int ACC_W   = 28;
   localparam int TEX_W   = 16;
   localparam int TEXEL_W = 13;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_LETTER_SCALE  = 3'd0;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
   localparam logic [2:0] REG_TEX_WIDTH     = 3'd3;
   localparam logic [2:0] REG_TEX_HEIGHT    = 3'd4;
   localparam logic [2:0] REG_MAX_CHARS     = 3'd5;

   localparam logic [15:0] LETTER_SCALE_RST  = 16'd256;
   localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd800;
   localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd600;
   localparam logic [12:0] TEX_WIDTH_RST     = 13'd256;
   localparam logic [12:0] TEX_HEIGHT_RST    = 13'd256;
   localparam logic [10:0] MAX_CHARS_RST     = 11'd64;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CHAR  = 1'b1;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   localparam logic signed [POS_W-1:0] POS_MAX = 21'sd1048575;
   localparam logic signed [POS_W-1:0] POS_MIN = -21'sd1048576;

   typedef struct packed {
      logic [15:0] letter_scale;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [12:0] tex_width;
      logic [12:0] tex_height;
      logic [10:0] max_chars;
   } cfg_type;

   // one glyph table entry, source x in the lowest bits
   typedef struct packed {
      logic [7:0]  x_advance;
      logic [7:0]  y_offset;
      logic [7:0]  x_offset;
      logic [7:0]  src_h;
      logic [7:0]  src_w;
      logic [11:0] src_y;
      logic [11:0] src_x;
   } glyph_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LEFT,
      ST_RIGHT,
      ST_TOP,
      ST_BOTTOM,
      ST_PEN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic [TEXEL_W-1:0] texel;
      logic [TEXEL_W-1:0] size;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [TEX_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [POS_W-1:0] sat21(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-POS_W){1'b0}}, POS_MAX};
      lo = {{(ACC_W-POS_W){1'b1}}, POS_MIN};
      if (v > hi) begin
         return POS_MAX;
      end else if (v < lo) begin
         return POS_MIN;
      end
      return v[POS_W-1:0];
   endfunction

endpackage

// ----- rtl/gqg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gqg_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/gqg_divider.sv -----
// Radix-2 restoring divider for texture coordinates: floor(texel*65536/size),
// saturated to 16 bits. Depends on gqg_pkg.
`timescale 1ns / 1ps

module gqg_divider (
   input  logic                clock,
   input  logic                reset,
   input  gqg_pkg::div_req_type req,
   output gqg_pkg::div_rsp_type rsp
);

   localparam int TW = gqg_pkg::TEXEL_W;
   localparam int QW = gqg_pkg::TEX_W;
   localparam int CW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [TW-1:0] size_ff, size_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [TW:0]   rem2;

   assign rem2 = {rem_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      size_in = size_ff;
      quot_in = quot_ff;
      if (req.start) begin
         size_in = req.size;
         cnt_in  = '0;
         // texel >= size means the quotient is 65536 or more
         if (req.texel >= req.size) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = req.texel;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, size_ff}) begin
            rem_in  = TW'(rem2 - {1'b0, size_ff});
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = rem2[TW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      size_ff <= size_in;
      quot_ff <= quot_in;
   end

   assign rsp = {done_ff, quot_ff};

endmodule

// ----- rtl/gqg_csr.sv -----
// APB-style configuration registers of the glyph quad generator.
// Depends on gqg_pkg.
`timescale 1ns / 1ps

module gqg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gqg_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gqg_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gqg_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output gqg_pkg::cfg_type                   cfg
);

   gqg_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            gqg_pkg::REG_LETTER_SCALE:  cfg_in.letter_scale  = pwdata[15:0];
            gqg_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[12:0];
            gqg_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[12:0];
            gqg_pkg::REG_TEX_WIDTH:     cfg_in.tex_width     = pwdata[12:0];
            gqg_pkg::REG_TEX_HEIGHT:    cfg_in.tex_height    = pwdata[12:0];
            gqg_pkg::REG_MAX_CHARS:     cfg_in.max_chars     = pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         gqg_pkg::REG_LETTER_SCALE:  prdata = {16'd0, cfg_ff.letter_scale};
         gqg_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, cfg_ff.screen_width};
         gqg_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_ff.screen_height};
         gqg_pkg::REG_TEX_WIDTH:     prdata = {19'd0, cfg_ff.tex_width};
         gqg_pkg::REG_TEX_HEIGHT:    prdata = {19'd0, cfg_ff.tex_height};
         gqg_pkg::REG_MAX_CHARS:     prdata = {21'd0, cfg_ff.max_chars};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.letter_scale  <= gqg_pkg::LETTER_SCALE_RST;
         cfg_ff.screen_width  <= gqg_pkg::SCREEN_WIDTH_RST;
         cfg_ff.screen_height <= gqg_pkg::SCREEN_HEIGHT_RST;
         cfg_ff.tex_width     <= gqg_pkg::TEX_WIDTH_RST;
         cfg_ff.tex_height    <= gqg_pkg::TEX_HEIGHT_RST;
         cfg_ff.max_chars     <= gqg_pkg::MAX_CHARS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/glyph_quad_generator_core.sv -----
// Top level of the glyph quad generator: sequencer, shared multiply-add unit,
// glyph table with valid bits. Depends on gqg_pkg, gqg_ram, gqg_divider, gqg_csr.
`timescale 1ns / 1ps

//  channel  | ports   | dir | contents
//  ---------+---------+-----+---------------------------------------------
//  request  | req_*   | in  | glyph write or character, 72-bit tdata
//  response | rsp_*   | out | one quad vertex per transaction, 4 per char
//  csr      | csr_*   | in  | APB-style, six registers at 4*index
//
//  A glyph write and a dropped character leave the sequencer idle. A character is
//  accepted, its table entry is read, then come 5 multiply-add steps and 4 divisions
//  in the shared restoring divider (which skips the bit steps when the quotient
//  saturates), then 4 vertex transactions, one per cycle at best.
//  req_tready is high only while the sequencer is idle; a stalled response holds
//  the sequencer in place.
//  Reset is synchronous and clears the glyph table valid bits, pen and count.

module glyph_quad_generator_core #(
   parameter int GLYPHS = gqg_pkg::GLYPHS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // code, src_x, src_y, src_w, src_h, x_offset, y_offset, x_advance
   input  logic [71:0]                    req_tdata,
   // func, first_char
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pos_x, pos_y, tex_u, tex_v, zero fill
   output logic [79:0]                    rsp_tdata,
   // corner
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gqg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gqg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gqg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
   localparam int PW = gqg_pkg::POS_W;
   localparam int XW = gqg_pkg::ACC_W;
   localparam int TW = gqg_pkg::TEX_W;

   gqg_pkg::cfg_type     cfg;
   gqg_pkg::state_type   state_ff, state_in;
   gqg_pkg::div_req_type div_req;
   gqg_pkg::div_rsp_type div_rsp;
   gqg_pkg::glyph_type   wr_glyph, rd_glyph, glyph_ff, glyph_in;

   logic             req_func, req_first;
   logic [7:0]       req_code;
   logic             req_fire, rsp_fire, in_range;
   logic [AW-1:0]    code_idx;
   logic             ram_we, ram_re;
   logic             div_start;
   logic [GLYPHS-1:0] valid_ff, valid_in;
   logic             hit_ff, hit_in;
   logic [10:0]      count_ff, count_in, count_eff;
   logic             drop;
   logic signed [PW-1:0] pen_ff, pen_in, pen_start;
   logic signed [XW-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [XW-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [TW-1:0]    quot_ff [4];
   logic [TW-1:0]    quot_in [4];
   logic [1:0]       div_idx_ff, div_idx_in;
   logic [1:0]       corner_ff, corner_in;

   // shared multiply-add unit: acc = addend +/- ma * mb
   logic signed [8:0]    mac_a;
   logic signed [17:0]   mac_b;
   logic signed [26:0]   mac_p;
   logic signed [XW-1:0] mac_addend, mac_acc;
   logic                 mac_sub;

   assign req_func  = req_tuser[0];
   assign req_first = req_tuser[1];
   assign req_code  = req_tdata[7:0];
   assign wr_glyph  = req_tdata[71:8];
   assign code_idx  = req_code[AW-1:0];
   assign in_range  = ({1'b0, req_code} < 9'(GLYPHS));
   assign req_fire  = req_tvalid & req_tready;
   assign rsp_fire  = rsp_tvalid & rsp_tready;
   assign pen_start = -$signed({1'b0, cfg.screen_width, 7'd0});
   assign count_eff = req_first ? 11'd0 : count_ff;
   assign drop      = (count_eff >= cfg.max_chars);

   gqg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   gqg_ram #(
      .WIDTH  ($bits(gqg_pkg::glyph_type)),
      .DEPTH  (GLYPHS),
      .ADDR_W (AW)
   ) u_glyph_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (code_idx),
      .wdata (wr_glyph),
      .re    (ram_re),
      .raddr (code_idx),
      .rdata (rd_glyph)
   );

   gqg_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gqg_pkg::ST_IDLE: begin
            if (req_fire && req_func == gqg_pkg::FUNC_CHAR && !drop) begin
               state_in = gqg_pkg::ST_READ;
            end
         end
         gqg_pkg::ST_READ:   state_in = gqg_pkg::ST_LEFT;
         gqg_pkg::ST_LEFT:   state_in = gqg_pkg::ST_RIGHT;
         gqg_pkg::ST_RIGHT:  state_in = gqg_pkg::ST_TOP;
         gqg_pkg::ST_TOP:    state_in = gqg_pkg::ST_BOTTOM;
         gqg_pkg::ST_BOTTOM: state_in = gqg_pkg::ST_PEN;
         gqg_pkg::ST_PEN:    state_in = gqg_pkg::ST_DIV_GO;
         gqg_pkg::ST_DIV_GO: state_in = gqg_pkg::ST_DIV_WAIT;
         gqg_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (div_idx_ff == 2'd3) ? gqg_pkg::ST_EMIT : gqg_pkg::ST_DIV_GO;
            end
         end
         gqg_pkg::ST_EMIT: begin
            if (rsp_fire && corner_ff == gqg_pkg::CORNER_LAST) begin
               state_in = gqg_pkg::ST_IDLE;
            end
         end
         default: state_in = gqg_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         gqg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_we     = req_tvalid & (req_func == gqg_pkg::FUNC_WRITE) & in_range;
            ram_re     = req_tvalid & (req_func == gqg_pkg::FUNC_CHAR);
         end
         gqg_pkg::ST_DIV_GO: div_start  = 1'b1;
         gqg_pkg::ST_EMIT:   rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // operand selection for the shared multiply-add and the divider
   always_comb begin
      mac_a      = '0;
      mac_b      = $signed({2'b00, cfg.letter_scale});
      mac_addend = {{(XW-PW){pen_ff[PW-1]}}, pen_ff};
      mac_sub    = 1'b0;
      unique case (state_ff)
         gqg_pkg::ST_LEFT: begin
            mac_a = $signed({glyph_ff.x_offset[7], glyph_ff.x_offset});
            mac_b = 18'sd256;
         end
         gqg_pkg::ST_RIGHT: begin
            mac_a      = $signed({1'b0, glyph_ff.src_w});
            mac_addend = left_ff;
         end
         gqg_pkg::ST_TOP: begin
            mac_a      = $signed({glyph_ff.y_offset[7], glyph_ff.y_offset});
            mac_addend = $signed({{(XW-20){1'b0}}, cfg.screen_height, 7'd0});
            mac_sub    = 1'b1;
         end
         gqg_pkg::ST_BOTTOM: begin
            mac_a      = $signed({1'b0, glyph_ff.src_h});
            mac_addend = top_ff;
            mac_sub    = 1'b1;
         end
         gqg_pkg::ST_PEN: mac_a = $signed({1'b0, glyph_ff.x_advance});
         default: ;
      endcase
   end

   assign mac_p   = mac_a * mac_b;
   assign mac_acc = mac_sub ? (mac_addend - {mac_p[26], mac_p})
                            : (mac_addend + {mac_p[26], mac_p});

   always_comb begin
      div_req.start = div_start;
      div_req.texel = {1'b0, glyph_ff.src_x};
      div_req.size  = div_idx_ff[1] ? cfg.tex_height : cfg.tex_width;
      unique case (div_idx_ff)
         2'd0: div_req.texel = {1'b0, glyph_ff.src_x};
         2'd1: div_req.texel = {1'b0, glyph_ff.src_x} + {5'd0, glyph_ff.src_w};
         2'd2: div_req.texel = {1'b0, glyph_ff.src_y};
         2'd3: div_req.texel = {1'b0, glyph_ff.src_y} + {5'd0, glyph_ff.src_h};
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      valid_in   = valid_ff;
      hit_in     = hit_ff;
      count_in   = count_ff;
      pen_in     = pen_ff;
      glyph_in   = glyph_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      quot_in    = quot_ff;
      div_idx_in = div_idx_ff;
      corner_in  = corner_ff;
      unique case (state_ff)
         gqg_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_func == gqg_pkg::FUNC_WRITE) begin
                  if (in_range) begin
                     valid_in[code_idx] = 1'b1;
                  end
               end else begin
                  // a dropped character still restarts the string
                  if (req_first) begin
                     pen_in = pen_start;
                  end
                  count_in = drop ? count_eff : count_eff + 11'd1;
                  hit_in   = in_range && valid_ff[code_idx];
               end
            end
            div_idx_in = '0;
            corner_in  = '0;
         end
         gqg_pkg::ST_READ:   glyph_in  = hit_ff ? rd_glyph : '0;
         gqg_pkg::ST_LEFT:   left_in   = mac_acc;
         gqg_pkg::ST_RIGHT:  right_in  = mac_acc;
         gqg_pkg::ST_TOP:    top_in    = mac_acc;
         gqg_pkg::ST_BOTTOM: bottom_in = mac_acc;
         gqg_pkg::ST_PEN:    pen_in    = gqg_pkg::sat21(mac_acc);
         gqg_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               quot_in[div_idx_ff] = div_rsp.quot;
               div_idx_in          = div_idx_ff + 2'd1;
            end
         end
         gqg_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               corner_in = corner_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gqg_pkg::ST_IDLE;
         valid_ff   <= '0;
         count_ff   <= '0;
         pen_ff     <= '0;
         div_idx_ff <= '0;
         corner_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         pen_ff     <= pen_in;
         div_idx_ff <= div_idx_in;
         corner_ff  <= corner_in;
      end
      hit_ff    <= hit_in;
      glyph_ff  <= glyph_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      quot_ff   <= quot_in;
   end

   // corner order: left on 0 and 2, top on 0 and 3
   logic sel_right, sel_bottom;
   logic signed [PW-1:0] out_x, out_y;
   logic [TW-1:0] out_u, out_v;

   assign sel_right  = corner_ff[0];
   assign sel_bottom = corner_ff[0] ^ corner_ff[1];
   assign out_x = gqg_pkg::sat21(sel_right ? right_ff : left_ff);
   assign out_y = gqg_pkg::sat21(sel_bottom ? bottom_ff : top_ff);
   assign out_u = sel_right ? quot_ff[1] : quot_ff[0];
   assign out_v = sel_bottom ? quot_ff[3] : quot_ff[2];

   assign rsp_tdata = {6'd0, out_v, out_u, out_y, out_x};
   assign rsp_tuser = corner_ff;
   assign rsp_tlast = (corner_ff == gqg_pkg::CORNER_LAST);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a vertex is pending");

   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == gqg_pkg::FUNC_WRITE) |=> req_tready)
      else $error("glyph write did not return to idle");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == gqg_pkg::ST_DIV_WAIT))
      else $error("divider finished outside its wait step");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("sequencer did not return to idle after the last vertex");

endmodule
